// ===== rtl/gmf_pkg.sv =====
// Shared types and constants for the group membership fanout block.
package gmf_pkg;

    localparam int UID_W      = 31;
    localparam int GID_W      = 10;
    localparam int GID_SPAN   = 1 << GID_W;
    localparam int QDEPTH     = 4;
    localparam int USERS_DEF  = 64;
    localparam int GROUPS_DEF = 1024;

    typedef enum logic [1:0] {
        OP_JOIN,
        OP_POST,
        OP_JOIN_BAD,
        OP_POST_BAD
    } op_t;

    typedef enum logic [2:0] {
        STS_JOINED     = 3'd0,
        STS_INVALID    = 3'd1,
        STS_FULL       = 3'd2,
        STS_NOT_MEMBER = 3'd3,
        STS_DELIVERY   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_SCAN,
        BS_SCAN_END,
        BS_DECIDE,
        BS_ROW_WR,
        BS_EMIT,
        BS_FAN_PICK,
        BS_FAN_OUT
    } bstate_t;

    typedef struct packed {
        op_t              op;
        logic [UID_W-1:0] uid;
    } cls_t;

endpackage

// ===== rtl/gmf_front.sv =====
// Input stage: accepts items, reduces the group number and classifies the request.
module gmf_front #(
    parameter int GROUPS = gmf_pkg::GROUPS_DEF,
    localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     kind,
    input  logic [gmf_pkg::GID_W-1:0] group_num,
    input  logic [gmf_pkg::UID_W-1:0] user_id,
    input  logic                     clr_busy,
    input  logic                     q_full,
    output logic                     push,
    output logic [GW-1:0]            push_grp,
    output gmf_pkg::cls_t            push_cls
);
    import gmf_pkg::*;

    localparam int FRAC_W = 20;

    logic             a_vld_reg, a_vld_next;
    logic             b_vld_reg, b_vld_next;
    logic             a_kind_reg, b_kind_reg;
    logic [GID_W-1:0] a_gid_reg, b_gid_reg;
    logic [UID_W-1:0] a_uid_reg, b_uid_reg;
    logic             accept;
    logic             a_adv;
    logic             b_adv;

    assign push     = b_vld_reg && !q_full;
    assign b_adv    = !b_vld_reg || push;
    assign a_adv    = a_vld_reg && b_adv;
    assign in_stall = clr_busy || (a_vld_reg && !b_adv);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        a_vld_next = a_vld_reg;
        if (accept)
        begin
            a_vld_next = 1'b1;
        end
        else if (a_adv)
        begin
            a_vld_next = 1'b0;
        end
        b_vld_next = b_vld_reg;
        if (a_adv)
        begin
            b_vld_next = 1'b1;
        end
        else if (push)
        begin
            b_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
            b_vld_reg <= b_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_kind_reg <= kind;
            a_gid_reg  <= group_num;
            a_uid_reg  <= user_id;
        end
        if (a_adv)
        begin
            b_kind_reg <= a_kind_reg;
            b_gid_reg  <= a_gid_reg;
            b_uid_reg  <= a_uid_reg;
        end
    end

    generate
        if (GROUPS < GID_SPAN)
        begin : g_mod
            localparam int RECIP = ((1 << FRAC_W) + GROUPS - 1) / GROUPS;
            logic [30:0]      prod;
            logic [GID_W-1:0] q_reg;
            logic [19:0]      qg;
            logic [19:0]      diff;

            // The reciprocal estimate is exact for a ten-bit group number.
            assign prod = 31'(a_gid_reg) * 31'(RECIP);
            always_ff @(posedge clk)
            begin
                if (a_adv)
                begin
                    q_reg <= prod[FRAC_W+GID_W-1:FRAC_W];
                end
            end
            assign qg       = 20'(q_reg) * 20'(GROUPS);
            assign diff     = 20'(b_gid_reg) - qg;
            assign push_grp = diff[GW-1:0];
        end
        else
        begin : g_pass
            assign push_grp = GW'(b_gid_reg);
        end
    endgenerate

    always_comb
    begin
        push_cls.uid = b_uid_reg;
        if (b_kind_reg)
        begin
            push_cls.op = (b_uid_reg == '0) ? OP_POST_BAD : OP_POST;
        end
        else
        begin
            push_cls.op = (b_uid_reg == '0) ? OP_JOIN_BAD : OP_JOIN;
        end
    end

endmodule

// ===== rtl/gmf_queue.sv =====
// Short request queue between the input stage and the table engine.
module gmf_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);
    import gmf_pkg::*;

    localparam int AW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    logic [W-1:0]  mem_reg [QDEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CW'(QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = CW'(cnt_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            cnt_next = CW'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("Queue written while full.");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("Queue read while empty.");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(QDEPTH))
        else $error("Queue count beyond depth.");
`endif

endmodule

// ===== rtl/gmf_back.sv =====
// Table engine: user slot search, membership update and delivery fanout.
module gmf_back #(
    parameter int USERS  = gmf_pkg::USERS_DEF,
    parameter int GROUPS = gmf_pkg::GROUPS_DEF,
    localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  logic [GW-1:0]             q_grp,
    input  gmf_pkg::cls_t             q_cls,
    output logic                      pop,
    output logic                      clr_busy,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                status,
    output logic [gmf_pkg::UID_W-1:0] dest_user,
    output logic                      last
);
    import gmf_pkg::*;

    localparam int SW = $clog2(USERS);
    localparam logic [GW-1:0] LAST_G = GW'(GROUPS - 1);
    localparam logic [SW-1:0] LAST_U = SW'(USERS - 1);

    typedef logic [USERS-1:0] row_t;

    function automatic row_t onehot(input logic [SW-1:0] idx);
        onehot = row_t'(1) << idx;
    endfunction

    function automatic logic [SW-1:0] lowest_set(input row_t r);
        logic [SW-1:0] idx;
        idx = '0;
        for (int i = USERS - 1; i >= 0; i--)
        begin
            if (r[i])
            begin
                idx = SW'(i);
            end
        end
        lowest_set = idx;
    endfunction

    bstate_t          state_reg, state_next;
    logic [GW-1:0]    clr_idx_reg, clr_idx_next;
    op_t              cur_op_reg, cur_op_next;
    logic [GW-1:0]    cur_grp_reg, cur_grp_next;
    logic [UID_W-1:0] cur_uid_reg, cur_uid_next;
    logic [SW-1:0]    scan_idx_reg, scan_idx_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [SW-1:0]    chk_idx_reg;
    logic             found_reg, found_next;
    logic [SW-1:0]    found_idx_reg, found_idx_next;
    logic             empty_found_reg, empty_found_next;
    logic [SW-1:0]    empty_idx_reg, empty_idx_next;
    row_t             rem_reg, rem_next;
    logic [SW-1:0]    fan_idx_reg, fan_idx_next;
    logic             fan_last_reg, fan_last_next;
    status_t          res_status_reg, res_status_next;
    logic [UID_W-1:0] res_dest_reg, res_dest_next;
    row_t             slot_vld_reg, slot_vld_next;
    logic             out_vld_reg, out_vld_next;
    status_t          out_status_reg, out_status_next;
    logic [UID_W-1:0] out_dest_reg, out_dest_next;
    logic             out_last_reg, out_last_next;

    logic [UID_W-1:0] slot_mem [USERS];
    row_t             row_mem [GROUPS];
    logic [UID_W-1:0] slot_rd_reg;
    row_t             row_rd_reg;

    logic [SW-1:0]    slot_raddr;
    logic             slot_we;
    logic             row_we;
    logic [GW-1:0]    row_waddr;
    row_t             row_wdata;
    logic             out_free;
    logic             out_load;
    logic             is_member;
    row_t             rem_calc;
    logic [SW-1:0]    pick;
    logic [SW-1:0]    join_idx;

    assign out_free  = !out_vld_reg || !out_stall;
    assign is_member = found_reg && row_rd_reg[found_idx_reg];
    assign rem_calc  = row_rd_reg & ~onehot(found_idx_reg);
    assign pick      = lowest_set(rem_reg);
    assign join_idx  = found_reg ? found_idx_reg : empty_idx_reg;
    assign clr_busy  = (state_reg == BS_CLEAR);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BS_CLEAR:
            begin
                if (clr_idx_reg == LAST_G)
                begin
                    state_next = BS_IDLE;
                end
            end
            BS_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_cls.op == OP_JOIN_BAD || q_cls.op == OP_POST_BAD)
                    begin
                        state_next = BS_EMIT;
                    end
                    else
                    begin
                        state_next = BS_SCAN;
                    end
                end
            end
            BS_SCAN:
            begin
                if (scan_idx_reg == LAST_U)
                begin
                    state_next = BS_SCAN_END;
                end
            end
            BS_SCAN_END:
            begin
                state_next = BS_DECIDE;
            end
            BS_DECIDE:
            begin
                if (cur_op_reg == OP_JOIN)
                begin
                    state_next = (found_reg || empty_found_reg) ? BS_ROW_WR : BS_EMIT;
                end
                else if (is_member)
                begin
                    state_next = (rem_calc != '0) ? BS_FAN_PICK : BS_IDLE;
                end
                else
                begin
                    state_next = BS_EMIT;
                end
            end
            BS_ROW_WR:
            begin
                state_next = BS_EMIT;
            end
            BS_EMIT:
            begin
                if (out_free)
                begin
                    state_next = BS_IDLE;
                end
            end
            BS_FAN_PICK:
            begin
                state_next = BS_FAN_OUT;
            end
            BS_FAN_OUT:
            begin
                if (out_free)
                begin
                    state_next = fan_last_reg ? BS_IDLE : BS_FAN_PICK;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop              = 1'b0;
        slot_raddr       = scan_idx_reg;
        slot_we          = 1'b0;
        row_we           = 1'b0;
        row_waddr        = cur_grp_reg;
        row_wdata        = row_rd_reg | onehot(join_idx);
        out_load         = 1'b0;
        clr_idx_next     = clr_idx_reg;
        cur_op_next      = cur_op_reg;
        cur_grp_next     = cur_grp_reg;
        cur_uid_next     = cur_uid_reg;
        scan_idx_next    = scan_idx_reg;
        chk_vld_next     = (state_reg == BS_SCAN);
        found_next       = found_reg;
        found_idx_next   = found_idx_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        rem_next         = rem_reg;
        fan_idx_next     = fan_idx_reg;
        fan_last_next    = fan_last_reg;
        res_status_next  = res_status_reg;
        res_dest_next    = res_dest_reg;
        slot_vld_next    = slot_vld_reg;
        out_status_next  = out_status_reg;
        out_dest_next    = out_dest_reg;
        out_last_next    = out_last_reg;

        if (chk_vld_reg)
        begin
            if (slot_vld_reg[chk_idx_reg] && slot_rd_reg == cur_uid_reg && !found_reg)
            begin
                found_next     = 1'b1;
                found_idx_next = chk_idx_reg;
            end
            if (!slot_vld_reg[chk_idx_reg] && !empty_found_reg)
            begin
                empty_found_next = 1'b1;
                empty_idx_next   = chk_idx_reg;
            end
        end

        case (state_reg)
            BS_CLEAR:
            begin
                row_we       = 1'b1;
                row_waddr    = clr_idx_reg;
                row_wdata    = '0;
                clr_idx_next = GW'(clr_idx_reg + 1'b1);
            end
            BS_IDLE:
            begin
                if (!q_empty)
                begin
                    pop              = 1'b1;
                    cur_op_next      = q_cls.op;
                    cur_grp_next     = q_grp;
                    cur_uid_next     = q_cls.uid;
                    scan_idx_next    = '0;
                    found_next       = 1'b0;
                    empty_found_next = 1'b0;
                    res_dest_next    = q_cls.uid;
                    res_status_next  = (q_cls.op == OP_JOIN_BAD) ? STS_INVALID
                                                                 : STS_NOT_MEMBER;
                end
            end
            BS_SCAN:
            begin
                scan_idx_next = SW'(scan_idx_reg + 1'b1);
            end
            BS_DECIDE:
            begin
                if (cur_op_reg == OP_JOIN)
                begin
                    res_status_next = STS_FULL;
                    if (!found_reg && empty_found_reg)
                    begin
                        slot_we                       = 1'b1;
                        slot_vld_next[empty_idx_reg]  = 1'b1;
                    end
                end
                else
                begin
                    res_status_next = STS_NOT_MEMBER;
                    rem_next        = rem_calc;
                end
            end
            BS_ROW_WR:
            begin
                row_we          = 1'b1;
                res_status_next = STS_JOINED;
            end
            BS_EMIT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = res_status_reg;
                    out_dest_next   = res_dest_reg;
                    out_last_next   = 1'b1;
                end
            end
            BS_FAN_PICK:
            begin
                slot_raddr    = pick;
                fan_idx_next  = pick;
                rem_next      = rem_reg & ~onehot(pick);
                fan_last_next = ((rem_reg & ~onehot(pick)) == '0);
            end
            BS_FAN_OUT:
            begin
                slot_raddr = fan_idx_reg;
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = STS_DELIVERY;
                    out_dest_next   = slot_rd_reg;
                    out_last_next   = fan_last_reg;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase

        out_vld_next = out_load ? 1'b1 : (out_vld_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BS_CLEAR;
            clr_idx_reg     <= '0;
            chk_vld_reg     <= 1'b0;
            found_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
            slot_vld_reg    <= '0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_idx_reg     <= clr_idx_next;
            chk_vld_reg     <= chk_vld_next;
            found_reg       <= found_next;
            empty_found_reg <= empty_found_next;
            slot_vld_reg    <= slot_vld_next;
            out_vld_reg     <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_op_reg     <= cur_op_next;
        cur_grp_reg    <= cur_grp_next;
        cur_uid_reg    <= cur_uid_next;
        scan_idx_reg   <= scan_idx_next;
        chk_idx_reg    <= scan_idx_reg;
        found_idx_reg  <= found_idx_next;
        empty_idx_reg  <= empty_idx_next;
        rem_reg        <= rem_next;
        fan_idx_reg    <= fan_idx_next;
        fan_last_reg   <= fan_last_next;
        res_status_reg <= res_status_next;
        res_dest_reg   <= res_dest_next;
        out_status_reg <= out_status_next;
        out_dest_reg   <= out_dest_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[empty_idx_reg] <= cur_uid_reg;
        end
        slot_rd_reg <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        row_rd_reg <= row_mem[cur_grp_reg];
    end

    assign out_valid = out_vld_reg;
    assign status    = out_status_reg;
    assign dest_user = out_dest_reg;
    assign last      = out_last_reg;

`ifndef ASSERT_OFF
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BS_CLEAR) |-> !pop)
        else $error("Request taken during the clearing pass.");
    a_alloc_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        slot_we |-> !slot_vld_reg[empty_idx_reg])
        else $error("Allocation overwrote an occupied slot.");
    a_pick_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BS_FAN_PICK) |-> (rem_reg != '0))
        else $error("Fanout step with no member left.");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("Result register loaded while still held.");
`endif

endmodule

// ===== rtl/group_membership_fanout_core.sv =====
// Top level of the multicast group membership table with delivery fanout.
//
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   kind, group_num, user_id
// result    out        out_valid / out_stall status, dest_user, last
//
// A join or a rejected post holds the table engine during the one-slot-per-cycle search
// of the user slot memory; a request with user id zero skips the search and is rejected.
// A post from a member is searched the same way, then delivered to each other member in turn.
// After reset the membership memory is cleared row by row with input stalled.
// A short queue lets new items enter while the engine works or the result is stalled.
module group_membership_fanout_core #(
    parameter int USERS  = gmf_pkg::USERS_DEF,
    parameter int GROUPS = gmf_pkg::GROUPS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      kind,
    input  logic [gmf_pkg::GID_W-1:0] group_num,
    input  logic [gmf_pkg::UID_W-1:0] user_id,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                status,
    output logic [gmf_pkg::UID_W-1:0] dest_user,
    output logic                      last
);
    import gmf_pkg::*;

    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int QW = GW + $bits(cls_t);

    logic          clr_busy;
    logic          q_full;
    logic          q_empty;
    logic          push;
    logic          pop;
    logic [GW-1:0] f_grp;
    cls_t          f_cls;
    logic [GW-1:0] q_grp;
    cls_t          q_cls;
    logic [QW-1:0] push_data;
    logic [QW-1:0] pop_data;

    assign push_data      = {f_grp, f_cls};
    assign {q_grp, q_cls} = pop_data;

    gmf_front #(
        .GROUPS(GROUPS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .group_num(group_num),
        .user_id  (user_id),
        .clr_busy (clr_busy),
        .q_full   (q_full),
        .push     (push),
        .push_grp (f_grp),
        .push_cls (f_cls)
    );

    gmf_queue #(
        .W(QW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .full     (q_full),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (q_empty)
    );

    gmf_back #(
        .USERS (USERS),
        .GROUPS(GROUPS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_grp    (q_grp),
        .q_cls    (q_cls),
        .pop      (pop),
        .clr_busy (clr_busy),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status   (status),
        .dest_user(dest_user),
        .last     (last)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the group membership fanout core: joins, posts and fanout against a predictor.
module tb;
    import gmf_pkg::*;

    localparam int NUM_USERS = USERS_DEF;
    localparam int NUM_GROUPS = GROUPS_DEF;
    localparam logic KIND_JOIN = 1'b0;
    localparam logic KIND_POST = 1'b1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 3 * NUM_USERS + 16;
    localparam int POOL_USERS = 32;
    localparam int POOL_GROUPS = 6;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        status_t          status;
        logic [UID_W-1:0] dest;
        logic             last;
    } result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic             kind = KIND_JOIN;
    logic [GID_W-1:0] group_num = '0;
    logic [UID_W-1:0] user_id = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [2:0]       status;
    logic [UID_W-1:0] dest_user;
    logic             last;

    logic [UID_W-1:0]     slot_uid [NUM_USERS];
    logic [NUM_USERS-1:0] group_rows [NUM_GROUPS];
    result_t              expected_results [$];
    logic [UID_W-1:0]     user_pool [POOL_USERS];
    logic [GID_W-1:0]     group_pool [POOL_GROUPS];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int items_sent = 0;
    int joins_sent = 0;
    int posts_sent = 0;
    int status_seen [5];

    group_membership_fanout_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .group_num (group_num),
        .user_id   (user_id),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .dest_user (dest_user),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycle_count, expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic int find_slot(logic [UID_W-1:0] uid);
        for (int i = 0; i < NUM_USERS; i++)
            if (slot_uid[i] == uid)
                return i;
        return NUM_USERS;
    endfunction

    function automatic void queue_result(status_t s, logic [UID_W-1:0] d, logic l);
        result_t r;
        r.status = s;
        r.dest = d;
        r.last = l;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_item(logic k, logic [GID_W-1:0] g, logic [UID_W-1:0] u);
        int grp;
        int slot;
        int prev;
        grp = int'(g) % NUM_GROUPS;
        if (k == KIND_JOIN)
        begin
            if (u == '0)
            begin
                queue_result(STS_INVALID, '0, 1'b1);
                return;
            end
            slot = find_slot(u);
            if (slot == NUM_USERS)
            begin
                slot = find_slot('0);
                if (slot == NUM_USERS)
                begin
                    queue_result(STS_FULL, u, 1'b1);
                    return;
                end
                slot_uid[slot] = u;
            end
            group_rows[grp][slot] = 1'b1;
            queue_result(STS_JOINED, u, 1'b1);
            return;
        end
        slot = (u == '0) ? NUM_USERS : find_slot(u);
        if (slot == NUM_USERS || !group_rows[grp][slot])
        begin
            queue_result(STS_NOT_MEMBER, u, 1'b1);
            return;
        end
        prev = -1;
        for (int i = 0; i < NUM_USERS; i++)
        begin
            if (i != slot && group_rows[grp][i])
            begin
                if (prev >= 0)
                    queue_result(STS_DELIVERY, slot_uid[prev], 1'b0);
                prev = i;
            end
        end
        if (prev >= 0)
            queue_result(STS_DELIVERY, slot_uid[prev], 1'b1);
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: unexpected result status=%0d dest=%h last=%b",
                             status, dest_user, last);
            end
            else
            begin
                want = expected_results.pop_front();
                if (status < 5)
                    status_seen[status]++;
                if (status !== want.status || dest_user !== want.dest || last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"ERROR: expected status=%0d dest=%h last=%b, ",
                                  "got status=%0d dest=%h last=%b"},
                                 want.status, want.dest, want.last, status, dest_user, last);
                end
            end
        end
    end

    task automatic send_item(input logic k, input logic [GID_W-1:0] g,
                             input logic [UID_W-1:0] u);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        group_num <= g;
        user_id <= u;
        do
            @(posedge clk);
        while (in_stall);
        predict_item(k, g, u);
        items_sent++;
        if (k == KIND_JOIN)
            joins_sent++;
        else
            posts_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_join_cases();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_item(KIND_JOIN, 10'd0, 31'd0);
        send_item(KIND_JOIN, 10'd1023, 31'h7FFF_FFFF);
        send_item(KIND_JOIN, 10'd1023, 31'd1);
        send_item(KIND_JOIN, 10'd1023, 31'h7FFF_FFFF);
        wait_idle();
    endtask

    task automatic test_post_cases();
        send_item(KIND_POST, 10'd1023, 31'h7FFF_FFFF);
        send_item(KIND_POST, 10'd1023, 31'd0);
        send_item(KIND_POST, 10'd0, 31'd1);
        send_item(KIND_POST, 10'd1023, 31'h2AAA_AAAA);
        send_item(KIND_JOIN, 10'd5, 31'd77);
        send_item(KIND_POST, 10'd5, 31'd77);
        wait_idle();
    endtask

    task automatic test_fanout();
        for (int i = 0; i < 8; i++)
            send_item(KIND_JOIN, 10'h155, 31'(32'h5555_0000 + i));
        send_item(KIND_POST, 10'h155, 31'h5555_0003);
        send_item(KIND_POST, 10'h155, 31'h5555_0007);
        send_item(KIND_POST, 10'h155, 31'h5555_0000);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int send_pct, input int stall_pct, input int count);
        int roll;
        logic k;
        logic [GID_W-1:0] g;
        logic [UID_W-1:0] u;
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            k = ($urandom_range(99) < 55) ? KIND_JOIN : KIND_POST;
            if ($urandom_range(9) == 0)
                g = GID_W'($urandom);
            else
                g = group_pool[$urandom_range(POOL_GROUPS - 1)];
            roll = $urandom_range(99);
            if (roll < 85)
                u = user_pool[$urandom_range(POOL_USERS - 1)];
            else if (roll < 92)
                u = '0;
            else
                u = UID_W'($urandom);
            send_item(k, g, u);
        end
        wait_idle();
    endtask

    task automatic test_table_full();
        logic [UID_W-1:0] newest;
        send_idle_pct = 20;
        recv_stall_pct = 20;
        newest = '0;
        while (find_slot('0) != NUM_USERS)
        begin
            newest = UID_W'($urandom_range(32'h7FFF_FFFF, 1));
            send_item(KIND_JOIN, group_pool[0], newest);
        end
        send_item(KIND_JOIN, group_pool[0], UID_W'($urandom_range(32'h7FFF_FFFF, 1)));
        send_item(KIND_JOIN, group_pool[1], UID_W'($urandom_range(32'h7FFF_FFFF, 1)));
        send_item(KIND_JOIN, group_pool[0], 31'd1);
        send_item(KIND_POST, group_pool[0], 31'd1);
        if (newest != '0)
            send_item(KIND_POST, group_pool[0], newest);
        wait_idle();
    endtask

    initial
    begin
        for (int i = 0; i < NUM_USERS; i++)
            slot_uid[i] = '0;
        for (int i = 0; i < NUM_GROUPS; i++)
            group_rows[i] = '0;
        for (int i = 0; i < 5; i++)
            status_seen[i] = 0;
        for (int i = 0; i < POOL_USERS; i++)
            user_pool[i] = UID_W'($urandom_range(32'h7FFF_FFFF, 1));
        for (int i = 0; i < POOL_GROUPS; i++)
            group_pool[i] = GID_W'($urandom);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_join_cases();
        test_post_cases();
        test_fanout();
        test_random_traffic(0, 0, 36);
        test_random_traffic(73, 0, 36);
        test_random_traffic(0, 73, 36);
        test_random_traffic(20, 20, 36);
        test_table_full();

        $display("Sent %0d items (%0d joins, %0d posts) in %0d cycles.",
                 items_sent, joins_sent, posts_sent, cycle_count);
        $display("Results: %0d joined, %0d invalid, %0d full, %0d rejected, %0d deliveries.",
                 status_seen[STS_JOINED], status_seen[STS_INVALID], status_seen[STS_FULL],
                 status_seen[STS_NOT_MEMBER], status_seen[STS_DELIVERY]);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== group_membership_fanout_core.f =====
rtl/gmf_pkg.sv
rtl/gmf_front.sv
rtl/gmf_queue.sv
rtl/gmf_back.sv
rtl/group_membership_fanout_core.sv
tb/tb.sv
